### hdl/dif_pkg.sv
// Shared types and constants for the decimal integer formatter.
package dif_pkg;

  localparam int MAX_WIDTH = 48;
  localparam int VALUE_W   = 32;
  localparam int DIGITS    = 10;
  localparam int STEP_W    = $clog2(VALUE_W);
  localparam int POS_W     = $clog2(MAX_WIDTH + 1);
  localparam int PADW_W    = 6;
  localparam int LEN_W     = 4;
  localparam int NIB_W     = $clog2(DIGITS);

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] REG_PAD_WIDTH    = 2'd0;
  localparam logic [1:0] REG_LEFT_JUSTIFY = 2'd1;
  localparam logic [1:0] REG_PLUS_SIGN    = 2'd2;
  localparam logic [1:0] REG_SPACE_SIGN   = 2'd3;

  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

endpackage

### hdl/dif_bcd_conv.sv
// Iterative binary to BCD converter: one shift-add-3 step per cycle.
module dif_bcd_conv
  import dif_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [VALUE_W-1:0] mag,
  output logic               done,
  output bcd_t               bcd
);

  logic                  running;
  logic [STEP_W-1:0]     cnt;
  logic [VALUE_W-1:0]    sh;
  bcd_t                  adj;
  logic [DIGITS*4-1:0]   adj_bits;

  // every digit >= 5 gets +3 before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  assign adj_bits = adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(VALUE_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh  <= mag;
      bcd <= '0;
    end else if (running) begin
      sh  <= {sh[VALUE_W-2:0], 1'b0};
      bcd <= {adj_bits[DIGITS*4-2:0], sh[VALUE_W-1]};
    end
  end

endmodule

### hdl/decimal_integer_formatter_top.sv
// Top level of the decimal integer formatter: config registers and character sequencer.
//
// A value taken with start (while busy is low) keeps the block busy through a
// single shift-add-3 unit (32 one-bit binary to BCD steps, then the hand-over
// of its done flag), a state that sizes the text, and then N = max(field width
// capped at 48, text length) characters, one per cycle, each on out_char for a
// single cycle with char_valid high and last_char on the final one. Each
// character is registered and appears in the cycle after its emit cycle, so the
// last one is on the ports in the first cycle with busy low. The receiver cannot
// stall; characters must be taken as they appear. Config writes are always ready
// and should only be made while busy is low.
module decimal_integer_formatter_top
  import dif_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [VALUE_W-1:0] value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [PADW_W-1:0]  cfg_data,
  output logic               char_valid,
  output logic [7:0]         out_char,
  output logic               last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [PADW_W-1:0]  pad_width;
  logic               left_justify;
  logic               plus_sign;
  logic               space_sign;

  logic               has_prefix;
  logic [7:0]         prefix_ch;
  logic [LEN_W-1:0]   nd;
  logic [LEN_W-1:0]   len;
  logic [POS_W-1:0]   lead;
  logic [POS_W-1:0]   total;
  logic [POS_W-1:0]   pos;

  logic               accept;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic               conv_done;
  bcd_t               bcd;

  logic [LEN_W-1:0]   nd_calc;
  logic [LEN_W-1:0]   len_calc;
  logic [POS_W-1:0]   w_sat;
  logic [POS_W-1:0]   len_ext;
  logic [POS_W-1:0]   pad_calc;

  logic [POS_W-1:0]   idx;
  logic [LEN_W-1:0]   di;
  logic [NIB_W-1:0]   nib;
  logic [7:0]         ch;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign neg       = (opcode == OP_SIGNED) && value[VALUE_W-1];
  assign mag       = neg ? (VALUE_W'(0) - value) : value;

  dif_bcd_conv u_conv (
    .clk  (clk),
    .rst  (rst),
    .go   (accept),
    .mag  (mag),
    .done (conv_done),
    .bcd  (bcd)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_width    <= '0;
      left_justify <= 1'b0;
      plus_sign    <= 1'b0;
      space_sign   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAD_WIDTH:    pad_width    <= cfg_data;
        REG_LEFT_JUSTIFY: left_justify <= cfg_data[0];
        REG_PLUS_SIGN:    plus_sign    <= cfg_data[0];
        REG_SPACE_SIGN:   space_sign   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // digit count: highest nonzero digit, zero counts as one digit
  always_comb begin
    nd_calc = LEN_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) nd_calc = LEN_W'(i + 1);
    end
    len_calc = nd_calc + LEN_W'(has_prefix);
    len_ext  = POS_W'(len_calc);
    w_sat    = (32'(pad_width) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : POS_W'(pad_width);
    pad_calc = (w_sat > len_ext) ? (w_sat - len_ext) : '0;
  end

  // character at the current position
  always_comb begin
    idx = pos - lead;
    di  = LEN_W'(idx) - LEN_W'(has_prefix);
    nib = NIB_W'(nd - di - LEN_W'(1));
    if (pos < lead || idx >= POS_W'(len)) begin
      ch = CH_SPACE;
    end else if (has_prefix && idx == '0) begin
      ch = prefix_ch;
    end else begin
      ch = CH_ZERO + 8'(bcd[nib]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
      pos        <= '0;
    end else begin
      char_valid <= 1'b0;
      case (state)
        ST_IDLE: if (accept) state <= ST_CONV;
        ST_CONV: if (conv_done) state <= ST_PREP;
        ST_PREP: begin
          pos   <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          char_valid <= 1'b1;
          pos        <= pos + 1'b1;
          if (pos == total - 1'b1) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (neg) begin
        has_prefix <= 1'b1;
        prefix_ch  <= CH_MINUS;
      end else if (opcode == OP_SIGNED && plus_sign) begin
        has_prefix <= 1'b1;
        prefix_ch  <= CH_PLUS;
      end else begin
        has_prefix <= space_sign;
        prefix_ch  <= CH_SPACE;
      end
    end
    if (state == ST_PREP) begin
      nd    <= nd_calc;
      len   <= len_calc;
      lead  <= left_justify ? '0 : pad_calc;
      total <= len_ext + pad_calc;
    end
    if (state == ST_EMIT) begin
      out_char  <= ch;
      last_char <= (pos == total - 1'b1);
    end
  end

endmodule

### verif/tb.sv
// Testbench for decimal_integer_formatter_top: directed table plus random values vs predictor.
module tb
  import dif_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int N_DIRECTED     = 24;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } char_beat_t;

  // txt holds the expected text right justified in a 12 char literal;
  // all zero means the row is checked against the predictor
  typedef struct {
    logic [PADW_W-1:0]  width;
    logic               left;
    logic               plus;
    logic               space;
    logic               op;
    logic [VALUE_W-1:0] val;
    logic [95:0]        txt;
  } dir_row_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic               opcode     = OP_SIGNED;
  logic [VALUE_W-1:0] value      = '0;
  logic               cfg_valid  = 1'b0;
  logic [1:0]         cfg_index  = REG_PAD_WIDTH;
  logic [PADW_W-1:0]  cfg_data   = '0;
  logic               busy;
  logic               cfg_ready;
  logic               char_valid;
  logic [7:0]         out_char;
  logic               last_char;

  // shadow of the format registers
  logic [PADW_W-1:0] fmt_width = '0;
  logic              fmt_left  = 1'b0;
  logic              fmt_plus  = 1'b0;
  logic              fmt_space = 1'b0;

  char_beat_t expected_chars[$];
  char_beat_t seen_beat;
  int         mismatches  = 0;
  int         idle_cycles = 0;
  dir_row_t   dir_rows[N_DIRECTED];

  decimal_integer_formatter_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_valid (char_valid),
    .out_char   (out_char),
    .last_char  (last_char)
  );

  always #5 clk = ~clk;

  function automatic void emit_char(input logic [7:0] ch);
    expected_chars.push_back('{code: ch, is_last: 1'b0});
  endfunction

  function automatic void mark_last();
    expected_chars[expected_chars.size()-1].is_last = 1'b1;
  endfunction

  function automatic void predict_text(input logic op, input logic [VALUE_W-1:0] v);
    logic [7:0]         sign_ch;
    logic [VALUE_W-1:0] mag;
    logic [7:0]         digs[DIGITS];
    int                 nd;
    int                 len;
    int                 w;
    int                 pad;
    sign_ch = 8'h00;
    if (op == OP_SIGNED && v[VALUE_W-1]) begin
      sign_ch = CH_MINUS;
      mag = 32'd0 - v;
    end else begin
      mag = v;
      if (op == OP_SIGNED && fmt_plus) sign_ch = CH_PLUS;
      else if (fmt_space) sign_ch = CH_SPACE;
    end
    nd = 0;
    do begin
      digs[nd] = CH_ZERO + 8'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0 && nd < DIGITS);
    len = nd + ((sign_ch != 8'h00) ? 1 : 0);
    w = (int'(fmt_width) > MAX_WIDTH) ? MAX_WIDTH : int'(fmt_width);
    pad = (w > len) ? w - len : 0;
    if (!fmt_left) repeat (pad) emit_char(CH_SPACE);
    if (sign_ch != 8'h00) emit_char(sign_ch);
    for (int i = nd - 1; i >= 0; i--) emit_char(digs[i]);
    if (fmt_left) repeat (pad) emit_char(CH_SPACE);
    mark_last();
  endfunction

  function automatic void queue_typed(input logic [95:0] txt);
    logic begun;
    begun = 1'b0;
    for (int i = 11; i >= 0; i--) begin
      if (txt[i*8 +: 8] != 8'h00) begun = 1'b1;
      if (begun) emit_char(txt[i*8 +: 8]);
    end
    mark_last();
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    int                 k;
    p = 32'd1;
    case ($urandom_range(0, 7))
      0: pick_value = $urandom_range(0, 20);
      1: begin
        k = $urandom_range(1, 9);
        repeat (k) p = p * 10;
        pick_value = p - $urandom_range(0, 1);
      end
      2: begin
        case ($urandom_range(0, 4))
          0: pick_value = 32'h0000_0000;
          1: pick_value = 32'h7FFF_FFFF;
          2: pick_value = 32'h8000_0000;
          3: pick_value = 32'h8000_0001;
          default: pick_value = 32'hFFFF_FFFF;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // lower start and wait until every char is out and the block is idle
  task automatic hold_until_drained();
    start <= 1'b0;
    while (expected_chars.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [PADW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_PAD_WIDTH:    fmt_width = data;
      REG_LEFT_JUSTIFY: fmt_left  = data[0];
      REG_PLUS_SIGN:    fmt_plus  = data[0];
      REG_SPACE_SIGN:   fmt_space = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_format(input logic [PADW_W-1:0] w, input logic l, input logic p,
                              input logic s);
    if (w != fmt_width || l != fmt_left || p != fmt_plus || s != fmt_space) begin
      hold_until_drained();
      if (w != fmt_width) cfg_write(REG_PAD_WIDTH, w);
      if (l != fmt_left)  cfg_write(REG_LEFT_JUSTIFY, {5'd0, l});
      if (p != fmt_plus)  cfg_write(REG_PLUS_SIGN, {5'd0, p});
      if (s != fmt_space) cfg_write(REG_SPACE_SIGN, {5'd0, s});
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic send_value(input logic op, input logic [VALUE_W-1:0] v,
                            input logic [95:0] typed);
    start  <= 1'b1;
    opcode <= op;
    value  <= v;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed != '0) queue_typed(typed);
    else predict_text(op, v);
  endtask

  task automatic sender_gap(input int n);
    start  <= 1'b0;
    opcode <= 1'($urandom);
    value  <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what);
    if (mismatches < 10) $display("%s", what);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (!rst && char_valid === 1'b1) begin
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char %h last %b", out_char, last_char));
      end else begin
        seen_beat = expected_chars.pop_front();
        if (out_char !== seen_beat.code || last_char !== seen_beat.is_last)
          note_mismatch($sformatf("char exp %h last %b, got %h last %b",
                                  seen_beat.code, seen_beat.is_last, out_char, last_char));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || char_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [PADW_W-1:0] w;
    int                idle_pct;
    dir_rows = '{
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'h0000_0000, "0"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'h0000_0001, "1"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'hFFFF_FFFF, "-1"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'h7FFF_FFFF, "2147483647"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'h8000_0000, "-2147483648"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_UNSIGNED, 32'hFFFF_FFFF, "4294967295"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_UNSIGNED, 32'h8000_0000, "2147483648"},
      '{6'd0,  1'b0, 1'b0, 1'b0, OP_UNSIGNED, 32'h0000_0000, "0"},
      '{6'd0,  1'b0, 1'b1, 1'b0, OP_SIGNED,   32'h0000_0000, "+0"},
      '{6'd0,  1'b0, 1'b1, 1'b0, OP_UNSIGNED, 32'h0000_0005, "5"},
      '{6'd0,  1'b0, 1'b1, 1'b0, OP_SIGNED,   32'h8000_0000, "-2147483648"},
      '{6'd0,  1'b0, 1'b0, 1'b1, OP_SIGNED,   32'd42,        " 42"},
      '{6'd0,  1'b0, 1'b0, 1'b1, OP_UNSIGNED, 32'd42,        " 42"},
      '{6'd0,  1'b0, 1'b1, 1'b1, OP_SIGNED,   32'd42,        "+42"},
      '{6'd0,  1'b0, 1'b1, 1'b1, OP_UNSIGNED, 32'hFFFF_FFFF, " 4294967295"},
      '{6'd0,  1'b0, 1'b0, 1'b1, OP_SIGNED,   32'hFFFF_FFFB, "-5"},
      '{6'd5,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'd42,        "   42"},
      '{6'd5,  1'b1, 1'b0, 1'b0, OP_SIGNED,   32'd42,        "42   "},
      '{6'd5,  1'b1, 1'b1, 1'b0, OP_SIGNED,   32'hFFFF_FFD6, "-42  "},
      '{6'd1,  1'b0, 1'b0, 1'b0, OP_SIGNED,   32'd12345,     "12345"},
      '{6'd11, 1'b0, 1'b0, 1'b0, OP_SIGNED,   32'h8000_0000, "-2147483648"},
      '{6'd48, 1'b0, 1'b0, 1'b0, OP_UNSIGNED, 32'hFFFF_FFFF, '0},
      '{6'd63, 1'b1, 1'b1, 1'b0, OP_SIGNED,   32'h8000_0000, '0},
      '{6'd49, 1'b0, 1'b0, 1'b1, OP_UNSIGNED, 32'h0000_0000, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      apply_format(dir_rows[i].width, dir_rows[i].left, dir_rows[i].plus, dir_rows[i].space);
      send_value(dir_rows[i].op, dir_rows[i].val, dir_rows[i].txt);
    end

    // phases: sender pauses after a value with 33% chance, then 72%, then never (one drain in the last)
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 33 : (phase == 1) ? 72 : 0;
      for (int batch = 0; batch < 4; batch++) begin
        case ($urandom_range(0, 5))
          0: w = 6'd0;
          1: w = 6'd63;
          2: w = 6'd48;
          3: w = 6'($urandom_range(0, 63));
          default: w = 6'($urandom_range(0, 14));
        endcase
        apply_format(w, 1'($urandom), 1'($urandom), 1'($urandom));
        for (int n = 0; n < 8; n++) begin
          send_value(1'($urandom), pick_value(), '0);
          if (phase == 2 && batch == 1 && n == 4)
            hold_until_drained();
          else if ($urandom_range(1, 100) <= idle_pct)
            sender_gap($urandom_range(1, 90));
        end
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
